@@ rtl/position_to_pwm_calibration_table_assert.svh @@
// assertion macros for the calibration table rtl
`ifndef POSITION_TO_PWM_CALIBRATION_TABLE_ASSERT_SVH
`define POSITION_TO_PWM_CALIBRATION_TABLE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptpc_pkg.sv @@
// shared types and constants of the calibration table
package ptpc_pkg;

    // field widths
    localparam int REQ_W   = 2;
    localparam int SERVO_W = 3;
    localparam int POS_W   = 16;
    localparam int PWM_W   = 12;

    // default geometry
    localparam int SERVOS_DEF     = 8;
    localparam int TABLE_SIZE_DEF = 64;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR    = 2'd0,
        REQ_RECORD   = 2'd1,
        REQ_FINALIZE = 2'd2,
        REQ_LOOKUP   = 2'd3
    } req_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [SERVO_W-1:0] servo_index;
        logic [POS_W-1:0]   position;
        logic [PWM_W-1:0]   pwm_value;
    } in_item_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_out;
        logic             calibrated;
    } out_item_t;

endpackage

@@ rtl/ptpc_ram.sv @@
// table storage: one write port, one registered read port
module ptpc_ram #(
    parameter int  DEPTH = ptpc_pkg::SERVOS_DEF * ptpc_pkg::TABLE_SIZE_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ptpc_pkg::PWM_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [ptpc_pkg::PWM_W-1:0] rdata
);
    import ptpc_pkg::*;

    logic [PWM_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ptpc_div.sv @@
// restoring divider, one quotient bit per cycle
module ptpc_div #(
    parameter int DEN_W = $clog2(ptpc_pkg::TABLE_SIZE_DEF)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptpc_pkg::PWM_W-1:0] dividend,
    input  logic [DEN_W-1:0]           divisor,
    output logic                       done,
    output logic [ptpc_pkg::PWM_W-1:0] quot,
    output logic [DEN_W-1:0]           rem
);
    import ptpc_pkg::*;

    localparam int CNT_W = $clog2(PWM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PWM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   partial;
    logic             fits;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        partial = {rem_reg, quot_reg[PWM_W-1]};
        fits    = (partial >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PWM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[PWM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(partial - {1'b0, den_reg}) : DEN_W'(partial);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/position_to_pwm_calibration_table.sv @@
// top level: request sequencer, row flags and result register of the calibration table
//
// One request is taken at a time; item_stall stays high until the request has finished
// its work, and the result waits in an output register, so the next request can be taken
// while the result is still unclaimed. Clear goes straight to its result. Record writes
// at once into a row already written since the last clear; the first record into a row
// after a clear (or reset) first sweeps that row to zero, one entry a cycle, before the
// write. Lookup adds a capture step after the registered read of the table memory.
// Finalize walks every written row through the table memory: each entry is read and
// checked, runs of empty entries are filled one entry a cycle, and each inner gap first
// waits on the shared 12-step divider that sets up the interpolation step; rows never
// written since the last clear are skipped. Reset and clear take effect at once through
// per-row valid flags; no clearing pass follows reset.
`include "position_to_pwm_calibration_table_assert.svh"

module position_to_pwm_calibration_table #(
    parameter int SERVOS     = ptpc_pkg::SERVOS_DEF,
    parameter int TABLE_SIZE = ptpc_pkg::TABLE_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ptpc_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output ptpc_pkg::out_item_t result
);
    import ptpc_pkg::*;

    localparam int CW    = $clog2(TABLE_SIZE);
    localparam int RW    = (SERVOS > 1) ? $clog2(SERVOS) : 1;
    localparam int DEPTH = SERVOS * TABLE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PROD_W = POS_W + 11;

    localparam logic [CW-1:0] LAST  = CW'(TABLE_SIZE - 1);
    localparam logic [RW-1:0] RLAST = RW'(SERVOS - 1);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DECODE    = 15'b000000000000010,
        S_CLEAR     = 15'b000000000000100,
        S_SWEEP     = 15'b000000000001000,
        S_REC       = 15'b000000000010000,
        S_LK_RD     = 15'b000000000100000,
        S_LK_CAP    = 15'b000000001000000,
        S_FIN_START = 15'b000000010000000,
        S_FIN_RD    = 15'b000000100000000,
        S_FIN_CHK   = 15'b000001000000000,
        S_FIN_DIV   = 15'b000010000000000,
        S_FIN_FILL  = 15'b000100000000000,
        S_FIN_NEXT  = 15'b001000000000000,
        S_FIN_ROW   = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // control flags
    logic [SERVOS-1:0] row_valid_reg;
    logic [SERVOS-1:0] row0_nz_reg;
    logic              result_valid_reg;
    out_item_t         result_reg;

    // request fields
    req_t              req_reg;
    logic [RW-1:0]     row_reg;
    logic              in_range_reg;
    logic [CW-1:0]     col_reg;
    logic [PWM_W-1:0]  pwm_reg;
    logic [PWM_W-1:0]  res_pwm_reg;

    // finalize walk
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     a_reg;
    logic [PWM_W-1:0]  va_reg;
    logic              found_reg;
    logic              tail_done_reg;
    logic [CW-1:0]     fill_k_reg;
    logic [CW-1:0]     fill_end_reg;
    logic [PWM_W-1:0]  fill_base_reg;
    logic              fill_const_reg;
    logic              fill_desc_reg;
    logic [CW-1:0]     den_reg;
    logic [PWM_W-1:0]  step_q_reg;
    logic [CW-1:0]     step_r_reg;
    logic [PWM_W-1:0]  acc_q_reg;
    logic [CW-1:0]     acc_r_reg;

    // memory and divider hookup
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [PWM_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [PWM_W-1:0]  mem_rdata;
    logic              div_start;
    logic [PWM_W-1:0]  div_dividend;
    logic [CW-1:0]     div_divisor;
    logic              div_done;
    logic [PWM_W-1:0]  div_quot;
    logic [CW-1:0]     div_rem;

    // misc combinational
    logic [PROD_W-1:0] bin_prod;
    logic [10:0]       bin_raw;
    logic [CW-1:0]     bin;
    logic              item_in_range;
    logic              transfer_out;
    logic              load_out;
    logic              chk_nz;
    logic              chk_gap;
    logic [PWM_W-1:0]  fill_val;
    logic [CW:0]       sum_r;
    logic              sum_wrap;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        addr_of = AW'(AW'(r) * AW'(TABLE_SIZE) + AW'(c));
    endfunction

    // bin of the incoming position, clamped to the last entry
    always_comb
    begin
        bin_prod      = PROD_W'(item.position) * PROD_W'(TABLE_SIZE);
        bin_raw       = bin_prod[PROD_W-1:POS_W];
        bin           = (bin_raw > 11'(TABLE_SIZE - 1)) ? LAST : CW'(bin_raw);
        item_in_range = (32'(item.servo_index) < SERVOS);
    end

    // output handshake
    assign transfer_out = result_valid_reg && !result_stall;
    assign load_out     = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    // finalize entry classification
    assign chk_nz  = (mem_rdata != '0);
    assign chk_gap = (i_reg != CW'(a_reg + CW'(1)));

    // gap interpolation value and running quotient/remainder
    always_comb
    begin
        if (fill_const_reg)
        begin
            fill_val = fill_base_reg;
        end
        else if (fill_desc_reg)
        begin
            fill_val = fill_base_reg - (acc_q_reg + PWM_W'(acc_r_reg != '0));
        end
        else
        begin
            fill_val = fill_base_reg + acc_q_reg;
        end
        sum_r    = {1'b0, acc_r_reg} + {1'b0, step_r_reg};
        sum_wrap = (sum_r >= {1'b0, den_reg});
    end

    // divider operands for an inner gap
    always_comb
    begin
        div_start    = (state_reg == S_FIN_CHK) && chk_nz && found_reg && chk_gap;
        div_dividend = (mem_rdata >= va_reg) ? (mem_rdata - va_reg) : (va_reg - mem_rdata);
        div_divisor  = i_reg - a_reg;
    end

    // memory port drive
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(row_reg, col_reg);
        mem_wdata = pwm_reg;
        mem_raddr = addr_of(row_reg, i_reg);
        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(row_reg, i_reg);
                mem_wdata = '0;
            end
            S_REC:
            begin
                mem_we = 1'b1;
            end
            S_LK_RD:
            begin
                mem_raddr = addr_of(row_reg, col_reg);
            end
            S_FIN_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(row_reg, fill_k_reg);
                mem_wdata = fill_val;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (req_reg)
                    REQ_CLEAR:    state_next = S_CLEAR;
                    REQ_RECORD:
                    begin
                        if (!in_range_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else if (row_valid_reg[row_reg])
                        begin
                            state_next = S_REC;
                        end
                        else
                        begin
                            state_next = S_SWEEP;
                        end
                    end
                    REQ_FINALIZE: state_next = S_FIN_START;
                    REQ_LOOKUP:   state_next = S_LK_RD;
                    default:      state_next = S_DONE;
                endcase
            end
            S_CLEAR:
            begin
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                if (i_reg == LAST)
                begin
                    state_next = S_REC;
                end
            end
            S_REC:
            begin
                state_next = S_DONE;
            end
            S_LK_RD:
            begin
                state_next = S_LK_CAP;
            end
            S_LK_CAP:
            begin
                state_next = S_DONE;
            end
            S_FIN_START:
            begin
                state_next = row_valid_reg[row_reg] ? S_FIN_RD : S_FIN_ROW;
            end
            S_FIN_RD:
            begin
                state_next = S_FIN_CHK;
            end
            S_FIN_CHK:
            begin
                priority if (chk_nz && !found_reg)
                begin
                    state_next = (i_reg != '0) ? S_FIN_FILL : S_FIN_NEXT;
                end
                else if (chk_nz && chk_gap)
                begin
                    state_next = S_FIN_DIV;
                end
                else
                begin
                    state_next = S_FIN_NEXT;
                end
            end
            S_FIN_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN_FILL;
                end
            end
            S_FIN_FILL:
            begin
                if (fill_k_reg == fill_end_reg)
                begin
                    state_next = S_FIN_NEXT;
                end
            end
            S_FIN_NEXT:
            begin
                priority if (i_reg != LAST)
                begin
                    state_next = S_FIN_RD;
                end
                else if (found_reg && !tail_done_reg && (a_reg != LAST))
                begin
                    state_next = S_FIN_FILL;
                end
                else
                begin
                    state_next = S_FIN_ROW;
                end
            end
            S_FIN_ROW:
            begin
                state_next = (row_reg == RLAST) ? S_DONE : S_FIN_START;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_valid_reg    <= '0;
            row0_nz_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // row flags
            if (state_reg == S_CLEAR)
            begin
                row_valid_reg <= '0;
                row0_nz_reg   <= '0;
            end
            if (state_reg == S_REC)
            begin
                row_valid_reg[row_reg] <= 1'b1;
                if (col_reg == '0)
                begin
                    row0_nz_reg[row_reg] <= (pwm_reg != '0);
                end
            end
            if ((state_reg == S_FIN_CHK) && chk_nz)
            begin
                row0_nz_reg[row_reg] <= 1'b1;
            end
            // result transfer, a new result wins over the one leaving
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (transfer_out)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg.pwm_out    <= res_pwm_reg;
            result_reg.calibrated <= &row0_nz_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg      <= req_t'(item.req_type);
                row_reg      <= RW'(item.servo_index);
                in_range_reg <= item_in_range;
                col_reg      <= bin;
                pwm_reg      <= item.pwm_value;
                i_reg        <= '0;
            end
            S_DECODE:
            begin
                res_pwm_reg <= '0;
                if (req_reg == REQ_FINALIZE)
                begin
                    row_reg <= '0;
                end
            end
            S_SWEEP:
            begin
                i_reg <= i_reg + CW'(1);
            end
            S_LK_CAP:
            begin
                res_pwm_reg <= (in_range_reg && row_valid_reg[row_reg]) ? mem_rdata : '0;
            end
            S_FIN_START:
            begin
                i_reg         <= '0;
                found_reg     <= 1'b0;
                tail_done_reg <= 1'b0;
            end
            S_FIN_CHK:
            begin
                if (chk_nz)
                begin
                    a_reg     <= i_reg;
                    va_reg    <= mem_rdata;
                    found_reg <= 1'b1;
                    if (!found_reg)
                    begin
                        // leading run copies the first filled entry
                        fill_k_reg     <= '0;
                        fill_end_reg   <= i_reg - CW'(1);
                        fill_base_reg  <= mem_rdata;
                        fill_const_reg <= 1'b1;
                    end
                    else
                    begin
                        // inner gap interpolates from the left entry
                        fill_k_reg     <= a_reg + CW'(1);
                        fill_end_reg   <= i_reg - CW'(1);
                        fill_base_reg  <= va_reg;
                        fill_const_reg <= 1'b0;
                        fill_desc_reg  <= (mem_rdata < va_reg);
                        den_reg        <= i_reg - a_reg;
                    end
                end
            end
            S_FIN_DIV:
            begin
                step_q_reg <= div_quot;
                step_r_reg <= div_rem;
                acc_q_reg  <= div_quot;
                acc_r_reg  <= div_rem;
            end
            S_FIN_FILL:
            begin
                fill_k_reg <= fill_k_reg + CW'(1);
                if (sum_wrap)
                begin
                    acc_r_reg <= CW'(sum_r - {1'b0, den_reg});
                    acc_q_reg <= acc_q_reg + step_q_reg + PWM_W'(1);
                end
                else
                begin
                    acc_r_reg <= CW'(sum_r);
                    acc_q_reg <= acc_q_reg + step_q_reg;
                end
            end
            S_FIN_NEXT:
            begin
                if (i_reg != LAST)
                begin
                    i_reg <= i_reg + CW'(1);
                end
                else if (found_reg && !tail_done_reg && (a_reg != LAST))
                begin
                    // trailing run copies the last filled entry
                    tail_done_reg  <= 1'b1;
                    fill_k_reg     <= a_reg + CW'(1);
                    fill_end_reg   <= LAST;
                    fill_base_reg  <= va_reg;
                    fill_const_reg <= 1'b1;
                end
            end
            S_FIN_ROW:
            begin
                if (row_reg != RLAST)
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            default:
            begin
                res_pwm_reg <= res_pwm_reg;
            end
        endcase
    end

    ptpc_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ptpc_div #(
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // fill stays inside its run
    `PTPC_ASSERT_IMPL(a_fill_in_run, clk, rst_n, state_reg == S_FIN_FILL, fill_k_reg <= fill_end_reg, "fill index past end of run")
    // interpolation remainder stays below the gap length
    `PTPC_ASSERT_IMPL(a_frac_below_den, clk, rst_n, (state_reg == S_FIN_FILL) && !fill_const_reg, acc_r_reg < den_reg, "interpolation remainder out of range")
    // rising gap never drops below its left value
    `PTPC_ASSERT_IMPL(a_rise_bounded, clk, rst_n, (state_reg == S_FIN_FILL) && !fill_const_reg && !fill_desc_reg, mem_wdata >= fill_base_reg, "rising interpolation below left value")
    // table is written only by sweep, record and fill
    `PTPC_ASSERT_IMPL(a_write_states, clk, rst_n, mem_we, (state_reg == S_SWEEP) || (state_reg == S_REC) || (state_reg == S_FIN_FILL), "table write outside a write step")
    // a finished request shows its result next cycle
    `PTPC_ASSERT_NEXT(a_done_loads, clk, rst_n, load_out, result_valid_reg && (state_reg == S_IDLE), "finished request did not reach the result register")

endmodule
